// ===== rtl/line_score_and_brighten_assert.svh =====
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef LINE_SCORE_AND_BRIGHTEN_ASSERT_SVH
`define LINE_SCORE_AND_BRIGHTEN_ASSERT_SVH

// The expression must never be true at a clock edge outside reset.
`define LSB_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LSB_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lsb_pkg
// Shared types, constants and the pixel brighten function of the line block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsb_pkg;

   localparam int STORE_BYTES   = 262144;
   localparam int MAX_DIMENSION = 1024;

   localparam int ADDR_W    = $clog2(STORE_BYTES);
   localparam int COORD_W   = $clog2(MAX_DIMENSION);
   localparam int DIM_W     = COORD_W + 1;
   localparam int CH_W      = 3;
   localparam int PIX_W     = 8;
   localparam int SCORE_W   = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = DIM_W;

   localparam int WY_W     = DIM_W + COORD_W;
   localparam int CORNER_W = CH_W + WY_W + 1;
   localparam int CHW_W    = CH_W + DIM_W;
   localparam int ERR_W    = COORD_W + 3;
   localparam int SUM_W    = $clog2(MAX_DIMENSION * 255 + 1);
   localparam int SQ_W     = 2 * COORD_W + 1;
   localparam int V_W      = SQ_W + 16;
   localparam int BIT_TOP  = ((V_W - 1) / 2) * 2;
   localparam int LEN_W    = (V_W + 1) / 2;
   localparam int DEN_W    = LEN_W + 8;
   localparam int NUM_W    = SUM_W + 22;
   localparam int OVF_W    = DEN_W + SCORE_W;
   localparam int DIV_W    = DEN_W + SCORE_W - 1;
   localparam int CNT_W    = $clog2(SCORE_W);

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
   localparam logic [PIX_W-1:0]   PIX_MAX   = {PIX_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMOUNT   = 3'd4;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_READ     = 2'd1,
      OP_SCORE    = 2'd2,
      OP_BRIGHTEN = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [ADDR_W-1:0]    addr;
      logic [PIX_W-1:0]     wbyte;
      logic [COORD_W-1:0]   x0;
      logic [COORD_W-1:0]   y0;
      logic [COORD_W-1:0]   x1;
      logic [COORD_W-1:0]   y1;
      logic                 bad;
      logic [ADDR_W-1:0]    start;
      logic [CHW_W-1:0]     chw;
   } cmd_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [PIX_W-1:0] brighten_pixel(input logic [PIX_W-1:0] p,
                                                       input logic mode,
                                                       input logic [PIX_W-1:0] amt);
      logic [2*PIX_W-1:0] frac;
      logic [PIX_W:0]     v;
      frac = (PIX_MAX - p) * amt;
      if (mode) begin
         v = {1'b0, p} + {1'b0, frac[2*PIX_W-1:PIX_W]};
      end else begin
         v = {1'b0, p} + {1'b0, amt};
      end
      return v[PIX_W] ? PIX_MAX : v[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lsb_queue.sv =====
// ----------------------------------------------------------------------------
// lsb_queue
// Two-entry request queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsb_queue import lsb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_ctrl_type   ctrl,
   input  wire cmd_type      push_cmd,
   output q_status_type      status,
   output cmd_type           head
);

   cmd_type    entry_ff [2];
   cmd_type    entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         entry_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (ctrl.pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + {1'b0, ctrl.push} - {1'b0, ctrl.pop};
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign status.full  = count_ff[1];
   assign status.empty = (count_ff == 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/lsb_front.sv =====
// ----------------------------------------------------------------------------
// lsb_front
// Accepts requests, checks line end points and computes pixel addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsb_front import lsb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic [ADDR_W-1:0]    req_byte_address,
   input  wire logic [PIX_W-1:0]     req_write_byte,
   input  wire logic [COORD_W-1:0]   req_start_x,
   input  wire logic [COORD_W-1:0]   req_start_y,
   input  wire logic [COORD_W-1:0]   req_end_x,
   input  wire logic [COORD_W-1:0]   req_end_y,
   input  wire logic [DIM_W-1:0]     cfg_width,
   input  wire logic [DIM_W-1:0]     cfg_height,
   input  wire logic [CH_W-1:0]      cfg_channels,
   input  wire q_status_type         q_status,
   output logic                      q_push,
   output cmd_type                   q_cmd
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type    state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [WY_W-1:0]    wy_ff, wy_in;
   logic [WY_W-1:0]    wy0_ff, wy0_in;
   logic               oob_ff, oob_in;
   logic [COORD_W-1:0] mx, my;
   logic [CORNER_W-1:0] corner;
   logic [CORNER_W-1:0] start_full;
   logic               is_line;

   assign mx      = (cmd_ff.x0 > cmd_ff.x1) ? cmd_ff.x0 : cmd_ff.x1;
   assign my      = (cmd_ff.y0 > cmd_ff.y1) ? cmd_ff.y0 : cmd_ff.y1;
   assign is_line = (cmd_ff.op == OP_SCORE) || (cmd_ff.op == OP_BRIGHTEN);

   // Corner address bounds the whole line, since addresses grow with x and y.
   assign corner     = CORNER_W'(cfg_channels) * CORNER_W'(wy_ff + WY_W'(mx));
   assign start_full = CORNER_W'(cfg_channels) * CORNER_W'(wy0_ff + WY_W'(cmd_ff.x0));

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      wy_in    = wy_ff;
      wy0_in   = wy0_ff;
      oob_in   = oob_ff;
      q_push   = 1'b0;
      q_cmd    = cmd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in.op    = op_type'(req_operation);
               cmd_in.addr  = req_byte_address;
               cmd_in.wbyte = req_write_byte;
               cmd_in.x0    = req_start_x;
               cmd_in.y0    = req_start_y;
               cmd_in.x1    = req_end_x;
               cmd_in.y1    = req_end_y;
               state_in     = F_MUL;
            end
         end
         F_MUL: begin
            wy_in      = WY_W'(cfg_width * my);
            wy0_in     = WY_W'(cfg_width * cmd_ff.y0);
            cmd_in.chw = CHW_W'(cfg_channels * cfg_width);
            oob_in     = (DIM_W'(mx) >= cfg_width) || (DIM_W'(my) >= cfg_height);
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            q_cmd.bad   = is_line && (oob_ff || (corner >= CORNER_W'(STORE_BYTES)));
            q_cmd.start = ADDR_W'(start_full);
            if (!q_status.full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      wy_ff  <= wy_in;
      wy0_ff <= wy0_in;
      oob_ff <= oob_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != F_IDLE);

endmodule

`default_nettype wire

// ===== rtl/lsb_engine.sv =====
// ----------------------------------------------------------------------------
// lsb_engine
// Executes queued requests: byte access, line walk, square root and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsb_engine import lsb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire q_status_type         q_status,
   input  wire cmd_type              head,
   output logic                      q_pop,
   input  wire logic [CH_W-1:0]      cfg_channels,
   input  wire logic                 cfg_mode,
   input  wire logic [PIX_W-1:0]     cfg_amount,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_status,
   output logic [PIX_W-1:0]          rsp_read_byte,
   output logic [SCORE_W-1:0]        rsp_line_score
);

   typedef enum logic [6:0] {
      E_IDLE   = 7'b0000001,
      E_RDWAIT = 7'b0000010,
      E_READ   = 7'b0000100,
      E_PIXEL  = 7'b0001000,
      E_SQRT   = 7'b0010000,
      E_DIVSET = 7'b0100000,
      E_DIV    = 7'b1000000
   } eng_state_type;

   logic [PIX_W-1:0] mem [STORE_BYTES];
   logic [PIX_W-1:0] rdata_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [PIX_W-1:0] mem_wdata;

   eng_state_type state_ff, state_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, x1_ff, x1_in, y1_ff, y1_in;
   logic               sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [ERR_W-1:0] dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CHW_W-1:0]   chw_ff, chw_in;
   logic               bright_ff, bright_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [V_W-1:0]     v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [SCORE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [PIX_W-1:0]   rsp_read_ff, rsp_read_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic               out_free, load;
   logic [COORD_W-1:0] hdx, hdy;
   logic [SQ_W-1:0]    sq_sum;
   logic signed [ERR_W:0] e2;
   logic               xgo, ygo, x_stop, y_stop, walk_done;
   logic [ADDR_W-1:0]  ch_step, row_step;
   logic [PIX_W-1:0]   bright_val;
   logic [V_W:0]       sq_try;
   logic [DEN_W-1:0]   den;
   logic [NUM_W-1:0]   num;
   logic               div_ge;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hdx = (head.x1 > head.x0) ? head.x1 - head.x0 : head.x0 - head.x1;
   assign hdy = (head.y1 > head.y0) ? head.y1 - head.y0 : head.y0 - head.y1;
   assign sq_sum = SQ_W'(hdx * hdx) + SQ_W'(hdy * hdy);

   // One Bresenham step: either the x move or the y move may end the walk.
   assign e2        = {err_ff, 1'b0};
   assign xgo       = (e2 >= (ERR_W+1)'(dy_ff));
   assign ygo       = (e2 <= (ERR_W+1)'(dx_ff));
   assign x_stop    = xgo && (x_ff == x1_ff);
   assign y_stop    = ygo && (y_ff == y1_ff);
   assign walk_done = x_stop || y_stop;
   assign ch_step   = ADDR_W'(cfg_channels);
   assign row_step  = ADDR_W'(chw_ff);
   assign bright_val = brighten_pixel(rdata_ff, cfg_mode, cfg_amount);

   assign sq_try = {1'b0, res_ff} + {1'b0, bit_ff};
   assign den    = DEN_W'({res_ff[LEN_W-1:0], 8'd0}) - DEN_W'(res_ff[LEN_W-1:0]);
   assign num    = {sum_ff, 22'd0};
   assign div_ge = (DIV_W'(rem_ff) >= div_ff);

   always_comb begin
      state_in  = state_ff;
      x_in = x_ff;  y_in = y_ff;  x1_in = x1_ff;  y1_in = y1_ff;
      sx_neg_in = sx_neg_ff;  sy_neg_in = sy_neg_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  err_in = err_ff;
      addr_in = addr_ff;  chw_in = chw_ff;  bright_in = bright_ff;
      sum_in = sum_ff;  v_in = v_ff;  res_in = res_ff;  bit_in = bit_ff;
      rem_in = rem_ff;  div_in = div_ff;  quo_in = quo_ff;  cnt_in = cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_score_in  = rsp_score_ff;
      load      = 1'b0;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_raddr = addr_ff;
      mem_wdata = bright_val;
      case (state_ff)
         E_IDLE: begin
            mem_waddr = head.addr;
            mem_raddr = head.addr;
            mem_wdata = head.wbyte;
            if (!q_status.empty && out_free) begin
               q_pop         = 1'b1;
               rsp_status_in = 1'b0;
               rsp_read_in   = '0;
               rsp_score_in  = '0;
               if (head.op == OP_WRITE) begin
                  mem_we = 1'b1;
                  load   = 1'b1;
               end else if (head.op == OP_READ) begin
                  state_in = E_RDWAIT;
               end else if (head.bad) begin
                  rsp_status_in = 1'b1;
                  load          = 1'b1;
               end else if (head.op == OP_SCORE && head.x0 == head.x1 &&
                            head.y0 == head.y1) begin
                  load = 1'b1;
               end else begin
                  x_in      = head.x0;
                  y_in      = head.y0;
                  x1_in     = head.x1;
                  y1_in     = head.y1;
                  sx_neg_in = !(head.x0 < head.x1);
                  sy_neg_in = !(head.y0 < head.y1);
                  dx_in     = ERR_W'(hdx);
                  dy_in     = -ERR_W'(hdy);
                  err_in    = ERR_W'(hdx) - ERR_W'(hdy);
                  addr_in   = head.start;
                  chw_in    = head.chw;
                  bright_in = (head.op == OP_BRIGHTEN);
                  sum_in    = '0;
                  v_in      = {sq_sum, 16'd0};
                  res_in    = '0;
                  bit_in    = V_W'(1) << BIT_TOP;
                  state_in  = E_READ;
               end
            end
         end
         E_RDWAIT: begin
            rsp_read_in = rdata_ff;
            load        = 1'b1;
            state_in    = E_IDLE;
         end
         E_READ: begin
            state_in = E_PIXEL;
         end
         E_PIXEL: begin
            sum_in = sum_ff + SUM_W'(PIX_MAX - rdata_ff);
            mem_we = bright_ff;
            if (walk_done) begin
               if (bright_ff) begin
                  load     = 1'b1;
                  state_in = E_IDLE;
               end else begin
                  state_in = E_SQRT;
               end
            end else begin
               err_in = err_ff + (xgo ? dy_ff : '0) + (ygo ? dx_ff : '0);
               if (xgo) begin
                  x_in    = sx_neg_ff ? x_ff - 1'b1 : x_ff + 1'b1;
               end
               if (ygo) begin
                  y_in    = sy_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1;
               end
               addr_in = addr_ff
                       + (xgo ? (sx_neg_ff ? -ch_step : ch_step) : '0)
                       + (ygo ? (sy_neg_ff ? -row_step : row_step) : '0);
               state_in = E_READ;
            end
         end
         E_SQRT: begin
            // Digit-by-digit square root; the length ends up in Q8.
            if ({1'b0, v_ff} >= sq_try) begin
               v_in   = v_ff - sq_try[V_W-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = E_DIVSET;
            end
         end
         E_DIVSET: begin
            if (OVF_W'(num) >= {den, SCORE_W'(0)}) begin
               rsp_score_in = SCORE_MAX;
               load         = 1'b1;
               state_in     = E_IDLE;
            end else begin
               rem_in   = num;
               div_in   = {den, (SCORE_W-1)'(0)};
               quo_in   = '0;
               cnt_in   = CNT_W'(SCORE_W - 1);
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            if (div_ge) begin
               rem_in = rem_ff - div_ff[NUM_W-1:0];
            end
            quo_in = {quo_ff[SCORE_W-2:0], div_ge};
            div_in = div_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rsp_score_in = {quo_ff[SCORE_W-2:0], div_ge};
               load         = 1'b1;
               state_in     = E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  x1_ff <= x1_in;  y1_ff <= y1_in;
      sx_neg_ff <= sx_neg_in;  sy_neg_ff <= sy_neg_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  err_ff <= err_in;
      addr_ff <= addr_in;  chw_ff <= chw_in;  bright_ff <= bright_in;
      sum_ff <= sum_in;  v_ff <= v_in;  res_ff <= res_in;  bit_ff <= bit_in;
      rem_ff <= rem_in;  div_ff <= div_in;  quo_ff <= quo_in;  cnt_ff <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_score_ff  <= rsp_score_in;
      if (reset) begin
         state_ff     <= E_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_byte  = rsp_read_ff;
   assign rsp_line_score = rsp_score_ff;

endmodule

`default_nettype wire

// ===== rtl/line_score_and_brighten.sv =====
// ----------------------------------------------------------------------------
// Line score and brighten block.
// Requests enter on the req_ channel (valid/stall) and carry one of four
// operations: write a byte, read a byte, score a line or brighten a line.
// Every request yields exactly one response on the rsp_ channel, in order.
// The csr_ channel writes the image geometry and brighten settings; it is
// always ready and should be used only while no request is in flight.
// The front stage registers each request, computes its addresses and checks
// its end points before it pushes it to the queue. The engine handles a write
// or an out-of-range line straight from the queue head, a read through the
// registered store read, and a line with one image read per visited pixel
// and, when brightening, a write back. Scoring adds 19 square root steps
// and a shift-and-subtract divide. A two-entry queue lets the front take
// new requests while the engine works or a response waits.
// Reset clears control state and restores register defaults; the image
// store is undefined until written. A stalled response holds its register
// and the engine waits, while the front keeps filling the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_score_and_brighten_assert.svh"

module line_score_and_brighten import lsb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [ADDR_W-1:0]     req_byte_address,
   input  wire logic [PIX_W-1:0]      req_write_byte,
   input  wire logic [COORD_W-1:0]    req_start_x,
   input  wire logic [COORD_W-1:0]    req_start_y,
   input  wire logic [COORD_W-1:0]    req_end_x,
   input  wire logic [COORD_W-1:0]    req_end_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_status,
   output logic [PIX_W-1:0]           rsp_read_byte,
   output logic [SCORE_W-1:0]         rsp_line_score,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_wdata
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [CH_W-1:0]  channels_ff, channels_in;
   logic             mode_ff, mode_in;
   logic [PIX_W-1:0] amount_ff, amount_in;

   q_ctrl_type   q_ctrl;
   q_status_type q_status;
   cmd_type      push_cmd, head;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      channels_in = channels_ff;
      mode_in     = mode_ff;
      amount_in   = amount_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:    width_in    = csr_wdata;
            CSR_HEIGHT:   height_in   = csr_wdata;
            CSR_CHANNELS: channels_in = csr_wdata[CH_W-1:0];
            CSR_MODE:     mode_in     = csr_wdata[0];
            CSR_AMOUNT:   amount_in   = csr_wdata[PIX_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_W'(256);
         height_ff   <= DIM_W'(256);
         channels_ff <= CH_W'(1);
         mode_ff     <= 1'b0;
         amount_ff   <= PIX_W'(32);
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         channels_ff <= channels_in;
         mode_ff     <= mode_in;
         amount_ff   <= amount_in;
      end
   end

   lsb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_byte_address (req_byte_address),
      .req_write_byte   (req_write_byte),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .cfg_width        (width_ff),
      .cfg_height       (height_ff),
      .cfg_channels     (channels_ff),
      .q_status         (q_status),
      .q_push           (q_ctrl.push),
      .q_cmd            (push_cmd)
   );

   lsb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .push_cmd (push_cmd),
      .status   (q_status),
      .head     (head)
   );

   lsb_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head           (head),
      .q_pop          (q_ctrl.pop),
      .cfg_channels   (channels_ff),
      .cfg_mode       (mode_ff),
      .cfg_amount     (amount_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_line_score (rsp_line_score)
   );

   `LSB_ASSERT_NEVER(a_no_push_full, q_ctrl.push && q_status.full, "push into full queue")
   `LSB_ASSERT_NEVER(a_no_pop_empty, q_ctrl.pop && q_status.empty, "pop from empty queue")
   `LSB_ASSERT_IMPLY(a_error_clean, rsp_valid && rsp_status,
                     rsp_read_byte == '0 && rsp_line_score == '0,
                     "error response carries data")

endmodule

`default_nettype wire
